// File: design/position_triggered_jet_scheduler_defines.svh
// Assertion macros for the jet scheduler.
`ifndef POSITION_TRIGGERED_JET_SCHEDULER_DEFINES_SVH
`define POSITION_TRIGGERED_JET_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PTJS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PTJS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTJS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define PTJS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: design/ptjs_pkg.sv
package ptjs_pkg;

	localparam int SLOTS_DEF     = 16;
	localparam int JETS_DEF      = 4;
	localparam int TICK_BITS_DEF = 16;

	localparam int JET_SLOTS = 4;
	localparam int JET_W     = 2;
	localparam int JET_IN_W  = 4;
	localparam int POS_W     = 32;
	localparam int PULSE_W   = 16;
	localparam int CNT_W     = 5;
	localparam int OP_W      = 3;
	localparam int STAT_W    = 2;
	localparam int REG_COUNT = 4;
	localparam int CFG_IDX_W = 3;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [OP_W-1:0] {
		OP_EDGE  = 3'd0,
		OP_TICK  = 3'd1,
		OP_QUEUE = 3'd2,
		OP_FIRE  = 3'd3,
		OP_ZERO  = 3'd4
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_BAD_JET = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	// Scan token that walks the slot chain, one cell per cycle.
	typedef struct packed {
		logic                 vld;
		logic                 ins;
		logic [JET_W-1:0]     ins_jet;
		logic [POS_W-1:0]     ins_pos;
		logic [JET_SLOTS-1:0] jet_on;
		logic [JET_SLOTS-1:0] started;
		logic [JET_SLOTS-1:0] fired;
		logic [CNT_W-1:0]     count;
	} tok_t;

endpackage

// File: design/ptjs_cell.sv
module ptjs_cell
	import ptjs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [POS_W-1:0] pos,
	input  tok_t             tok_i,
	output tok_t             tok_o
);

	logic             valid_q;
	logic [JET_W-1:0] jet_q;
	logic [POS_W-1:0] pos_q;

	tok_t             tok_n;
	logic             occ;
	logic             wr;
	logic [JET_W-1:0] sj;
	logic [POS_W-1:0] sp;
	logic             hit;

	// An insert lands in the first cell that was empty when the token arrived,
	// and the new entry is checked against the position in the same step.
	always_comb begin
		tok_n = tok_i;
		occ   = valid_q;
		sj    = jet_q;
		sp    = pos_q;
		wr    = 1'b0;
		if (tok_i.ins && !valid_q) begin
			occ       = 1'b1;
			sj        = tok_i.ins_jet;
			sp        = tok_i.ins_pos;
			tok_n.ins = 1'b0;
			wr        = 1'b1;
		end
		hit = occ && ($signed(pos) >= $signed(sp));
		if (hit) begin
			tok_n.fired[sj] = 1'b1;
			if (!tok_i.jet_on[sj]) begin
				tok_n.jet_on[sj]  = 1'b1;
				tok_n.started[sj] = 1'b1;
			end
			occ = 1'b0;
		end
		if (occ) begin
			tok_n.count = tok_i.count + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_o   <= '0;
		end else begin
			tok_o <= tok_n;
			if (tok_i.vld) begin
				valid_q <= occ;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_i.vld && wr) begin
			jet_q <= sj;
			pos_q <= sp;
		end
	end

endmodule

// File: design/position_triggered_jet_scheduler.sv
// From an accepted request, the result passes start_q, the SLOT_COUNT slot cells and ST_HOLD before
// it shows on m_tvalid; ST_HOLD waits while an earlier result is not yet taken. A new request is
// taken only in ST_IDLE. The scan token visits one slot cell per cycle, so the cell chain length sets the rate.
// Reset (arst_n low, asynchronous): all slots empty, position zero, jets off,
// pulse times zero, no result pending.
`include "position_triggered_jet_scheduler_defines.svh"

module position_triggered_jet_scheduler
	import ptjs_pkg::*;
#(
	parameter int SLOT_COUNT = SLOTS_DEF,
	parameter int JET_COUNT  = JETS_DEF,
	parameter int TICK_BITS  = TICK_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// op [2:0], jet [6:3], trigger_position [38:7], zero [39]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// jet_drive [3:0], fired_mask [7:4], position_now [39:8],
	// pending_count [44:40], status [46:45], zero [47]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [PULSE_W-1:0]    cfg_wdata
);

	localparam logic [32:0] TICK_MAX = (33'd1 << TICK_BITS) - 33'd1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;

	logic [PULSE_W-1:0]   pulse_q [JET_SLOTS];
	logic [POS_W-1:0]     enc_q;
	logic [JET_SLOTS-1:0] jet_on_q;
	logic [TICK_BITS-1:0] ticks_q [JET_SLOTS];

	logic                 start_q;
	logic                 ins_q;
	logic [JET_W-1:0]     ijet_q;
	logic [POS_W-1:0]     trig_q;
	logic                 bad_q;

	logic [JET_SLOTS-1:0] res_drive_q;
	logic [JET_SLOTS-1:0] res_fired_q;
	logic [POS_W-1:0]     res_pos_q;
	logic [CNT_W-1:0]     res_count_q;
	status_t              res_status_q;
	logic                 out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	tok_t tok_chain [SLOT_COUNT+1];

	logic [OP_W-1:0]     in_op;
	logic [JET_IN_W-1:0] in_jet;
	logic [POS_W-1:0]    in_trig;
	logic                accept;
	logic                jet_ok;
	logic                scan_done;
	logic                out_free;

	function automatic logic [TICK_BITS-1:0] pulse_load(input logic [PULSE_W-1:0] p);
		logic [TICK_BITS-1:0] r;
		if (33'(p) > TICK_MAX) begin
			r = TICK_MAX[TICK_BITS-1:0];
		end else begin
			r = TICK_BITS'(p);
		end
		return r;
	endfunction

	assign in_op     = s_tdata[2:0];
	assign in_jet    = s_tdata[6:3];
	assign in_trig   = s_tdata[38:7];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign jet_ok    = (in_jet < JET_IN_W'(JET_COUNT));
	assign scan_done = tok_chain[SLOT_COUNT].vld;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Token launched into the first cell in the cycle after the request is accepted.
	always_comb begin
		tok_chain[0].vld     = start_q;
		tok_chain[0].ins     = ins_q;
		tok_chain[0].ins_jet = ijet_q;
		tok_chain[0].ins_pos = trig_q;
		tok_chain[0].jet_on  = jet_on_q;
		tok_chain[0].started = '0;
		tok_chain[0].fired   = '0;
		tok_chain[0].count   = '0;
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		ptjs_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.pos   (enc_q),
			.tok_i (tok_chain[i]),
			.tok_o (tok_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (out_valid_q && m_tready && (state_q != ST_HOLD)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Position, jet timers and pulse registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= '0;
			jet_on_q <= '0;
			for (int j = 0; j < JET_SLOTS; j++) begin
				pulse_q[j] <= '0;
				ticks_q[j] <= '0;
			end
		end else begin
			if (cfg_we && (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
				pulse_q[cfg_index[JET_W-1:0]] <= cfg_wdata;
			end
			if (accept) begin
				case (in_op)
					OP_EDGE: begin
						enc_q <= enc_q + POS_W'(1);
					end
					OP_TICK: begin
						for (int j = 0; j < JET_SLOTS; j++) begin
							if (jet_on_q[j]) begin
								if (ticks_q[j] > TICK_BITS'(1)) begin
									ticks_q[j] <= ticks_q[j] - TICK_BITS'(1);
								end else begin
									ticks_q[j]  <= '0;
									jet_on_q[j] <= 1'b0;
								end
							end
						end
					end
					OP_FIRE: begin
						if (jet_ok) begin
							jet_on_q[in_jet[JET_W-1:0]] <= 1'b1;
							ticks_q[in_jet[JET_W-1:0]]  <=
								pulse_load(pulse_q[in_jet[JET_W-1:0]]);
						end
					end
					OP_ZERO: begin
						enc_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (scan_done) begin
				jet_on_q <= tok_chain[SLOT_COUNT].jet_on;
				for (int j = 0; j < JET_SLOTS; j++) begin
					if (tok_chain[SLOT_COUNT].started[j]) begin
						ticks_q[j] <= pulse_load(pulse_q[j]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q  <= (in_op == OP_QUEUE) && jet_ok;
			ijet_q <= in_jet[JET_W-1:0];
			trig_q <= in_trig;
			bad_q  <= ((in_op == OP_QUEUE) || (in_op == OP_FIRE)) && !jet_ok;
		end
		if (scan_done) begin
			res_drive_q <= tok_chain[SLOT_COUNT].jet_on;
			res_fired_q <= tok_chain[SLOT_COUNT].fired;
			res_pos_q   <= enc_q;
			res_count_q <= tok_chain[SLOT_COUNT].count;
			// An insert still riding the token found no empty slot.
			if (bad_q) begin
				res_status_q <= STAT_BAD_JET;
			end else if (tok_chain[SLOT_COUNT].ins) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= STAT_OK;
			end
		end
		if ((state_q == ST_HOLD) && out_free) begin
			out_data_q <= {1'b0, res_status_q, res_count_q, res_pos_q,
				res_fired_q, res_drive_q};
		end
	end

	`PTJS_ASSERT_IMP(a_token_in_scan, clk, arst_n, scan_done, state_q == ST_SCAN, "token left chain outside scan")
	`PTJS_ASSERT_NXT(a_accept_scans, clk, arst_n, accept, start_q && (state_q == ST_SCAN), "accepted request did not start a scan")
	`PTJS_ASSERT_IMP(a_fired_on, clk, arst_n, out_valid_q, (m_tdata[7:4] & ~m_tdata[3:0]) == 4'b0000, "fired jet not driven")

endmodule
